// ----- rtl/tfr_pkg.sv -----
package tfr_pkg;

  localparam logic [7:0]  LEAD_FIRST     = 8'hAA;
  localparam logic [7:0]  LEAD_SECOND    = 8'h55;
  localparam logic [7:0]  TYPE_TELEMETRY = 8'h01;
  localparam logic [7:0]  TYPE_HELLO     = 8'h02;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_INIT       = 16'h0000;
  localparam logic [15:0] CO2_NONE       = 16'hFFFF;
  localparam logic [4:0]  TELEMETRY_LEN  = 5'd14;
  localparam logic [4:0]  HELLO_LEN      = 5'd17;
  localparam logic [4:0]  POS_TYPE       = 5'd2;
  localparam logic [4:0]  POS_PAYLOAD    = 5'd3;
  localparam int          PAYLOAD_DEPTH  = 13;
  localparam int          PAYLOAD_IDX_W  = $clog2(PAYLOAD_DEPTH);

  typedef struct packed {
    logic               frame_kind;
    logic [15:0]        co2_ppm;
    logic               co2_valid;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic [15:0]        battery_mv;
    logic [7:0]         status_flags;
    logic [15:0]        fw_version;
    logic [7:0]         build_options;
    logic [31:0]        build_time;
    logic [31:0]        source_rev;
  } tfr_result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- rtl/tfr_deframer.sv -----
module tfr_deframer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  logic [7:0]           byte_data,
  input  logic                 paused,
  input  logic                 clear,
  output logic                 res_valid,
  output tfr_pkg::tfr_result_t res
);
  import tfr_pkg::*;

  logic                     lead_seen, lead_seen_next;
  logic [4:0]               byte_count, byte_count_next;
  logic                     frame_is_hello, frame_is_hello_next;
  logic [15:0]              running_crc, running_crc_next;
  logic [7:0]               payload [PAYLOAD_DEPTH];
  logic                     pay_we;
  logic [PAYLOAD_IDX_W-1:0] pay_idx;
  logic [4:0]               frame_len;
  logic [15:0]              crc_got;

  assign frame_len = frame_is_hello ? HELLO_LEN : TELEMETRY_LEN;
  assign pay_idx   = PAYLOAD_IDX_W'(byte_count - POS_PAYLOAD);
  assign crc_got   = {byte_data, frame_is_hello ? payload[12] : payload[9]};

  always_comb begin
    lead_seen_next      = lead_seen;
    byte_count_next     = byte_count;
    frame_is_hello_next = frame_is_hello;
    running_crc_next    = running_crc;
    pay_we              = 1'b0;
    res_valid           = 1'b0;
    if (byte_valid && !paused) begin
      if (!lead_seen) begin
        if (byte_count == 5'd1 && byte_data == LEAD_SECOND) begin
          lead_seen_next   = 1'b1;
          byte_count_next  = POS_TYPE;
          running_crc_next = CRC_INIT;
        end else begin
          byte_count_next = (byte_data == LEAD_FIRST) ? 5'd1 : 5'd0;
        end
      end else if (byte_count <= POS_TYPE) begin
        if (byte_data == TYPE_TELEMETRY || byte_data == TYPE_HELLO) begin
          frame_is_hello_next = (byte_data == TYPE_HELLO);
          running_crc_next    = crc_byte(CRC_INIT, byte_data);
          byte_count_next     = POS_PAYLOAD;
        end else begin
          lead_seen_next  = 1'b0;
          byte_count_next = 5'd0;
        end
      end else if (byte_count >= frame_len) begin
        lead_seen_next  = 1'b0;
        byte_count_next = 5'd0;
      end else if (byte_count + 5'd2 < frame_len) begin
        pay_we           = 1'b1;
        running_crc_next = crc_byte(running_crc, byte_data);
        byte_count_next  = byte_count + 5'd1;
      end else if (byte_count + 5'd2 == frame_len) begin
        pay_we          = 1'b1;
        byte_count_next = byte_count + 5'd1;
      end else begin
        lead_seen_next  = 1'b0;
        byte_count_next = 5'd0;
        res_valid       = (crc_got == running_crc);
      end
    end
    if (clear) begin
      lead_seen_next  = 1'b0;
      byte_count_next = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_seen      <= 1'b0;
      byte_count     <= 5'd0;
      frame_is_hello <= 1'b0;
      running_crc    <= CRC_INIT;
    end else begin
      lead_seen      <= lead_seen_next;
      byte_count     <= byte_count_next;
      frame_is_hello <= frame_is_hello_next;
      running_crc    <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      payload[pay_idx] <= byte_data;
    end
  end

  always_comb begin
    res = '0;
    if (frame_is_hello) begin
      res.frame_kind    = 1'b1;
      res.fw_version    = {payload[2], payload[1]};
      res.build_options = payload[3];
      res.build_time    = {payload[7], payload[6], payload[5], payload[4]};
      res.source_rev    = {payload[11], payload[10], payload[9], payload[8]};
    end else begin
      res.frame_kind   = 1'b0;
      res.co2_ppm      = {payload[1], payload[0]};
      res.co2_valid    = ({payload[1], payload[0]} != CO2_NONE);
      res.temperature  = {payload[3], payload[2]};
      res.humidity     = {payload[5], payload[4]};
      res.battery_mv   = {payload[7], payload[6]};
      res.status_flags = payload[8];
    end
  end

endmodule

// ----- rtl/telemetry_frame_receiver.sv -----
// Serial telemetry deframer. Bytes come in on the in_valid/in_stall channel,
// one byte per transaction; decoded frames leave on out_valid/out_stall, one
// transaction per frame whose CRC-16 checks. Bad or unknown frames give nothing.
// The pause register is written over cfg_valid/cfg_ready (cfg_ready is always
// high); while it is set, bytes are taken and discarded, and clearing it
// restarts the lead hunt.
// Throughput: one byte per cycle while in_stall is low. A byte is held in an input
// register, then processed by the combinational CRC and field logic into a
// two-entry result queue, whose output register offers the result, or whose
// skid entry keeps it while the output stalls.
// When the receiver stalls, results wait in the queue; in_stall rises only when
// the queue together with the byte in flight could overflow it.
// Reset clears the pause register, the deframer and the queue; the payload
// store itself holds whatever it last received.
module telemetry_frame_receiver (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               receive_paused,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_kind,
  output logic [15:0]        co2_ppm,
  output logic               co2_valid,
  output logic signed [15:0] temperature,
  output logic [15:0]        humidity,
  output logic [15:0]        battery_mv,
  output logic [7:0]         status_flags,
  output logic [15:0]        fw_version,
  output logic [7:0]         build_options,
  output logic [31:0]        build_time,
  output logic [31:0]        source_rev
);
  import tfr_pkg::*;

  logic        paused;
  logic        clear;
  logic        byte_v;
  logic [7:0]  byte_r;
  logic        res_valid;
  tfr_result_t res;
  tfr_result_t out_data;
  logic        skid_valid;
  tfr_result_t skid_data;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign clear     = cfg_valid && paused && !receive_paused;
  assign in_stall  = (out_valid && skid_valid) || ((out_valid || skid_valid) && byte_v);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      paused <= 1'b0;
    end else if (cfg_valid) begin
      paused <= receive_paused;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_v <= 1'b0;
    end else begin
      byte_v <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= rx_byte;
    end
  end

  tfr_deframer u_deframer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_v),
    .byte_data  (byte_r),
    .paused     (paused),
    .clear      (clear),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  assign frame_kind    = out_data.frame_kind;
  assign co2_ppm       = out_data.co2_ppm;
  assign co2_valid     = out_data.co2_valid;
  assign temperature   = out_data.temperature;
  assign humidity      = out_data.humidity;
  assign battery_mv    = out_data.battery_mv;
  assign status_flags  = out_data.status_flags;
  assign fw_version    = out_data.fw_version;
  assign build_options = out_data.build_options;
  assign build_time    = out_data.build_time;
  assign source_rev    = out_data.source_rev;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with output register empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid && out_stall) |-> !skid_valid)
    else $error("result queue overflow");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (byte_v && !paused))
    else $error("result without a processed byte");

  a_stall_guard: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !(out_valid && skid_valid && byte_v))
    else $error("byte taken with no room for its result");

endmodule
